// File: hw/rtl/signed_integer_to_radix_digits_unit_defines.svh
// Assertion macros for the radix digit converter.
// Included by the top level; expects clk and rst in scope.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_UNIT_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIRD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sird_pkg.sv
// Shared types and constants for the radix digit converter.
// No dependencies; used by the interfaces, the divider and the top level.
`default_nettype none

package sird_pkg;

  localparam int RADIX_W  = 7;
  localparam int INDEX_W  = 6;
  localparam int SYMBOL_W = 8;
  localparam int DIGIT_W  = 6;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [SYMBOL_W-1:0] SYM_MINUS  = 8'd45;
  localparam logic [SYMBOL_W-1:0] SYM_PLUS   = 8'd43;
  localparam logic [SYMBOL_W-1:0] PRINT_LOW  = 8'd32;
  localparam logic [SYMBOL_W-1:0] PRINT_HIGH = 8'd126;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_RD,
    S_CHK_TEST,
    S_BAD,
    S_DIV_START,
    S_DIV_WAIT,
    S_SIGN,
    S_POP_RD,
    S_POP_SYM,
    S_POP_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/sird_if.sv
// Valid/ready channel interfaces for input items and output characters.
// Depends on sird_pkg for field widths.
`default_nettype none

interface sird_in_if #(
  parameter int NUMBER_WIDTH = 32
);
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic [sird_pkg::INDEX_W-1:0]         symbol_index;
  logic [sird_pkg::SYMBOL_W-1:0]        symbol_char;
  logic signed [NUMBER_WIDTH-1:0]       number;

  modport source (output valid, operation, symbol_index, symbol_char, number,
                  input ready);
  modport sink   (input valid, operation, symbol_index, symbol_char, number,
                  output ready);
endinterface

interface sird_out_if;
  logic                          valid;
  logic                          ready;
  logic [sird_pkg::SYMBOL_W-1:0] out_char;
  logic                          last;
  logic                          bad_base;

  modport source (output valid, out_char, last, bad_base, input ready);
  modport sink   (input valid, out_char, last, bad_base, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sird_divider.sv
// Restoring divider: one quotient bit per cycle, divisor up to RADIX_W bits.
// Depends on sird_pkg.
`default_nettype none

module sird_divider #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [NUMBER_WIDTH-1:0]          dividend,
  input  wire logic [sird_pkg::RADIX_W-1:0]     divisor,
  output sird_pkg::div_status_t                 status,
  output logic      [NUMBER_WIDTH-1:0]          quotient,
  output logic      [sird_pkg::RADIX_W:0]       remainder
);

  localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);
  localparam int REM_W = sird_pkg::RADIX_W + 1;

  logic [NUMBER_WIDTH-1:0]          quo;
  logic [REM_W-1:0]                 rem;
  logic [sird_pkg::RADIX_W-1:0]     dvs;
  logic [CNT_W-1:0]                 cnt;
  logic                             busy;
  logic                             done;
  logic [REM_W-1:0]                 trial;
  logic                             fits;

  // Partial remainder stays below the divisor, so its top bit is free.
  assign trial = {rem[REM_W-2:0], quo[NUMBER_WIDTH-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUMBER_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, dvs}) : trial;
      quo <= {quo[NUMBER_WIDTH-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;
  assign remainder   = rem;

endmodule

`default_nettype wire

// File: hw/rtl/signed_integer_to_radix_digits_unit.sv
// Flow: a load item writes the alphabet table on accept; a bad base or alphabet gives one bad-base beat.
// Convert: check the alphabet, divide out each digit, then emit an optional minus sign and the digits.
// Throughput: one item at a time; the slowest item is the most negative 32-bit number in
// base 2 (two-symbol check), set by the bit-serial divider (one quotient bit per cycle).
// Reset: synchronous, active high; clears radix, sequencer, output valid and work registers.
`default_nettype none

`include "signed_integer_to_radix_digits_unit_defines.svh"

module signed_integer_to_radix_digits_unit #(
  parameter int MAX_RADIX    = 64,
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [sird_pkg::RADIX_W-1:0] cfg_wr_data,
  sird_in_if.sink                           item_in,
  sird_out_if.source                        char_out
);

  localparam int AW    = $clog2(MAX_RADIX);
  localparam int SW    = $clog2(NUMBER_WIDTH);
  localparam int CW    = $clog2(NUMBER_WIDTH + 1);
  localparam int RW    = sird_pkg::RADIX_W;
  localparam int SYM_W = sird_pkg::SYMBOL_W;
  localparam int DW    = sird_pkg::DIGIT_W;
  localparam logic [RW:0] MAX_RADIX_V = (RW + 1)'(MAX_RADIX);

  // Configuration register: the base, which is also the alphabet size.
  logic [RW-1:0] radix;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= '0;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  sird_pkg::state_t state, state_next;

  logic in_acc, load_acc, conv_acc, radix_bad;

  assign item_in.ready = (state == sird_pkg::S_IDLE);
  assign in_acc    = item_in.valid && item_in.ready;
  assign load_acc  = in_acc && (item_in.operation == sird_pkg::OP_LOAD);
  assign conv_acc  = in_acc && (item_in.operation == sird_pkg::OP_CONVERT);
  assign radix_bad = (radix < RW'(2)) || ({1'b0, radix} > MAX_RADIX_V);

  // Alphabet table: one write port for load beats, one registered read port
  // shared by the check pass and the character lookup.
  logic [SYM_W-1:0] alpha_mem [MAX_RADIX];
  logic [SYM_W-1:0] alpha_rdata;
  logic [AW-1:0]    alpha_raddr;
  logic             alpha_rd_en;

  // Digit stack: digits come out least significant first, pop them reversed.
  logic [DW-1:0] stack_mem [NUMBER_WIDTH];
  logic [DW-1:0] stack_rdata;
  logic [CW-1:0] depth;
  logic [CW-1:0] depth_dec;

  // Work registers.
  logic [NUMBER_WIDTH-1:0] mag;
  logic                    neg;
  logic [RW-1:0]           sym_pos;
  logic [255:0]            seen;
  logic                    sym_bad;

  // Shared divider.
  logic                    div_start;
  sird_pkg::div_status_t   div_status;
  logic [NUMBER_WIDTH-1:0] div_quot;
  logic [RW:0]             div_rem;

  // Output register.
  logic             out_valid;
  logic [SYM_W-1:0] out_char;
  logic             out_last;
  logic             out_bad;
  logic             out_free;
  logic             out_load;
  logic [SYM_W-1:0] out_char_next;
  logic             out_last_next;
  logic             out_bad_next;

  assign depth_dec = depth - CW'(1);
  assign out_free  = !out_valid || char_out.ready;

  // Index fits the table only when below MAX_RADIX; the narrowing is then lossless.
  always_ff @(posedge clk) begin
    if (load_acc && ({1'b0, item_in.symbol_index} < MAX_RADIX_V)) begin
      alpha_mem[AW'({1'b0, item_in.symbol_index})] <= item_in.symbol_char;
    end
  end

  assign alpha_rd_en = (state == sird_pkg::S_CHK_RD) || (state == sird_pkg::S_POP_SYM);
  assign alpha_raddr = (state == sird_pkg::S_CHK_RD) ? AW'(sym_pos)
                                                     : AW'({1'b0, stack_rdata});

  always_ff @(posedge clk) begin
    if (alpha_rd_en) begin
      alpha_rdata <= alpha_mem[alpha_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == sird_pkg::S_DIV_WAIT && div_status.done) begin
      stack_mem[depth[SW-1:0]] <= div_rem[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == sird_pkg::S_POP_RD) begin
      stack_rdata <= stack_mem[depth_dec[SW-1:0]];
    end
  end

  sird_divider #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (radix),
    .status    (div_status),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // A symbol fails if it is a sign, not printable, or already seen.
  assign sym_bad = (alpha_rdata == sird_pkg::SYM_MINUS) ||
                   (alpha_rdata == sird_pkg::SYM_PLUS)  ||
                   (alpha_rdata <  sird_pkg::PRINT_LOW) ||
                   (alpha_rdata >  sird_pkg::PRINT_HIGH) ||
                   seen[alpha_rdata];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sird_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_char_next = '0;
    out_last_next = 1'b0;
    out_bad_next  = 1'b0;
    case (state)
      sird_pkg::S_IDLE: begin
        if (conv_acc) begin
          state_next = radix_bad ? sird_pkg::S_BAD : sird_pkg::S_CHK_RD;
        end
      end
      sird_pkg::S_CHK_RD: begin
        state_next = sird_pkg::S_CHK_TEST;
      end
      sird_pkg::S_CHK_TEST: begin
        if (sym_bad) begin
          state_next = sird_pkg::S_BAD;
        end else if (sym_pos + RW'(1) == radix) begin
          state_next = sird_pkg::S_DIV_START;
        end else begin
          state_next = sird_pkg::S_CHK_RD;
        end
      end
      sird_pkg::S_BAD: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_last_next = 1'b1;
          out_bad_next  = 1'b1;
          state_next    = sird_pkg::S_IDLE;
        end
      end
      sird_pkg::S_DIV_START: begin
        div_start  = 1'b1;
        state_next = sird_pkg::S_DIV_WAIT;
      end
      sird_pkg::S_DIV_WAIT: begin
        if (div_status.done) begin
          if (div_quot != '0) begin
            state_next = sird_pkg::S_DIV_START;
          end else begin
            state_next = neg ? sird_pkg::S_SIGN : sird_pkg::S_POP_RD;
          end
        end
      end
      sird_pkg::S_SIGN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_char_next = sird_pkg::SYM_MINUS;
          state_next    = sird_pkg::S_POP_RD;
        end
      end
      sird_pkg::S_POP_RD: begin
        state_next = sird_pkg::S_POP_SYM;
      end
      sird_pkg::S_POP_SYM: begin
        state_next = sird_pkg::S_POP_OUT;
      end
      sird_pkg::S_POP_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_char_next = alpha_rdata;
          out_last_next = (depth == '0);
          state_next    = (depth == '0) ? sird_pkg::S_IDLE : sird_pkg::S_POP_RD;
        end
      end
      default: begin
        state_next = sird_pkg::S_IDLE;
      end
    endcase
  end

  // Work registers: magnitude, sign, check position, seen map, stack depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      mag     <= '0;
      neg     <= 1'b0;
      sym_pos <= '0;
      seen    <= '0;
      depth   <= '0;
    end else begin
      case (state)
        sird_pkg::S_IDLE: begin
          if (conv_acc) begin
            // Negate in the unsigned domain: the most negative value maps to itself.
            neg     <= item_in.number[NUMBER_WIDTH-1];
            mag     <= item_in.number[NUMBER_WIDTH-1] ? (~item_in.number + 1'b1)
                                                      : item_in.number;
            sym_pos <= '0;
            seen    <= '0;
            depth   <= '0;
          end
        end
        sird_pkg::S_CHK_TEST: begin
          seen[alpha_rdata] <= 1'b1;
          sym_pos           <= sym_pos + RW'(1);
        end
        sird_pkg::S_DIV_WAIT: begin
          if (div_status.done) begin
            mag   <= div_quot;
            depth <= depth + CW'(1);
          end
        end
        sird_pkg::S_POP_RD: begin
          depth <= depth_dec;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: hold the beat until taken, load a new one when free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (char_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= out_char_next;
      out_last <= out_last_next;
      out_bad  <= out_bad_next;
    end
  end

  assign char_out.valid    = out_valid;
  assign char_out.out_char = out_char;
  assign char_out.last     = out_last;
  assign char_out.bad_base = out_bad;

  `SIRD_ASSERT_IMPLY(a_ready_div_idle, item_in.ready, !div_status.busy, "ready while divider busy")
  `SIRD_ASSERT_IMPLY(a_done_in_wait, div_status.done, state == sird_pkg::S_DIV_WAIT, "stray divider done")
  `SIRD_ASSERT_NEXT(a_last_to_idle, out_load && out_last_next, state == sird_pkg::S_IDLE, "no idle after last beat")
  `SIRD_ASSERT_IMPLY(a_bad_form, out_valid && out_bad, out_char == 8'h00 && out_last, "malformed bad-base beat")
  `SIRD_ASSERT_IMPLY(a_depth_range, 1'b1, depth <= CW'(NUMBER_WIDTH), "digit stack overflow")

endmodule

`default_nettype wire
